[rtl/core/yuyv2rgb_pkg.sv]
// ----------------------------------------------------------------------------
// yuyv2rgb_pkg
// Shared types, constants and helpers of the YUYV 4:2:2 to RGB888 converter.
// ----------------------------------------------------------------------------
package yuyv2rgb_pkg;

    // Width of the configuration word and its value after reset.
    localparam int CFG_W             = 13;
    localparam int FRAME_WIDTH_RESET = 640;
    localparam int MAX_WIDTH_DEFAULT = 4096;

    // Depth of the queue between the front and the back end.
    localparam int QUEUE_DEPTH = 2;

    // BT.601 integer coefficients and offsets.
    localparam int COEF_Y    = 298;
    localparam int COEF_RV   = 409;
    localparam int COEF_GU   = 100;
    localparam int COEF_GV   = 208;
    localparam int COEF_BU   = 516;
    localparam int LUMA_OFS  = 16;
    localparam int ROUND_OFS = 128;

    // Width of a channel sum before the shift.
    localparam int SUM_W = 20;

    // One macropixel with its row flags, as queued between front and back.
    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] chroma_red;
        logic       second_valid;
        logic       row_end;
    } yuyv2rgb_item_t;

    // Floor shift by eight, then clamp to 0..255.
    function automatic logic [7:0] shift_clamp(input logic signed [SUM_W-1:0] sum);
        logic [SUM_W-9:0] sh;
        logic [7:0]       res;
        sh = sum[SUM_W-1:8];
        if (sh[SUM_W-9])
            res = 8'd0;
        else if (|sh[SUM_W-10:8])
            res = 8'd255;
        else
            res = sh[7:0];
        return res;
    endfunction

endpackage

[rtl/core/yuyv2rgb_front.sv]
// ----------------------------------------------------------------------------
// yuyv2rgb_front
// Accepts macropixels, holds the row width and the column counter, and tags
// each beat with its second-pixel and row-end flags before queueing it.
// ----------------------------------------------------------------------------
module yuyv2rgb_front #(
    parameter int MAX_WIDTH = yuyv2rgb_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [yuyv2rgb_pkg::CFG_W-1:0]    cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,
    input  logic                              q_full,
    output logic                              q_push,
    output yuyv2rgb_pkg::yuyv2rgb_item_t      q_item
);
    import yuyv2rgb_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int EW  = $clog2(MAX_WIDTH + 1);
    localparam int CLW = (EW > CFG_W) ? EW : CFG_W;
    localparam int XW  = EW + 1;
    localparam int RESET_WIDTH =
        (FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RESET;

    logic [EW-1:0]  width_reg;
    logic [EW-1:0]  width_next;
    logic [CW-1:0]  column_reg;
    logic [CW-1:0]  column_next;
    logic [CLW-1:0] cfg_ext;
    logic [XW-1:0]  col_plus1;
    logic [XW-1:0]  col_plus2;
    logic [XW-1:0]  width_ext;
    logic           second_ok;
    logic           last_pair;

    // Configuration is always taken; the width is stored already clamped.
    assign cfg_ready = 1'b1;
    assign cfg_ext   = CLW'(cfg_data);

    always_comb
    begin
        width_next = width_reg;
        if (cfg_valid)
        begin
            if (cfg_ext == '0)
                width_next = EW'(1);
            else if (cfg_ext > CLW'(MAX_WIDTH))
                width_next = EW'(MAX_WIDTH);
            else
                width_next = EW'(cfg_ext);
        end
    end

    // Row position checks for the pair about to be accepted.
    assign col_plus1 = XW'(column_reg) + XW'(1);
    assign col_plus2 = XW'(column_reg) + XW'(2);
    assign width_ext = XW'(width_reg);
    assign second_ok = col_plus1 < width_ext;
    assign last_pair = col_plus2 >= width_ext;

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    always_comb
    begin
        q_item.luma_first   = s_axis_tdata[7:0];
        q_item.chroma_blue  = s_axis_tdata[15:8];
        q_item.luma_second  = s_axis_tdata[23:16];
        q_item.chroma_red   = s_axis_tdata[31:24];
        q_item.second_valid = second_ok;
        q_item.row_end      = last_pair;
    end

    // Column counter moves on by a pair per beat and wraps at row end.
    always_comb
    begin
        column_next = column_reg;
        if (q_push)
        begin
            if (last_pair)
                column_next = '0;
            else
                column_next = CW'(col_plus2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= EW'(RESET_WIDTH);
            column_reg <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            column_reg <= column_next;
        end
    end

endmodule

[rtl/core/yuyv2rgb_queue.sv]
// ----------------------------------------------------------------------------
// yuyv2rgb_queue
// Short first-in first-out queue of tagged macropixels between the front
// and the back end.
// ----------------------------------------------------------------------------
module yuyv2rgb_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  yuyv2rgb_pkg::yuyv2rgb_item_t  push_item,
    output logic                          full,
    input  logic                          pop,
    output logic                          not_empty,
    output yuyv2rgb_pkg::yuyv2rgb_item_t  pop_item
);
    import yuyv2rgb_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    yuyv2rgb_item_t mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [NW-1:0]  count_reg;
    logic [NW-1:0]  count_next;
    logic           do_push;
    logic           do_pop;

    assign full      = (count_reg == NW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + NW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - NW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

[rtl/core/yuyv2rgb_back.sv]
// ----------------------------------------------------------------------------
// yuyv2rgb_back
// Two-stage colour conversion: coefficient products, then sums, rounding and
// clamping into the output register that drives the result stream.
// ----------------------------------------------------------------------------
module yuyv2rgb_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_not_empty,
    input  yuyv2rgb_pkg::yuyv2rgb_item_t  q_item,
    output logic                          q_pop,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [47:0]                   m_axis_tdata,
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast
);
    import yuyv2rgb_pkg::*;

    localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(ROUND_OFS);

    // Stage one: products.
    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [16:0]         s1_y0_reg;
    logic [16:0]         s1_y1_reg;
    logic signed [16:0]  s1_rv_reg;
    logic signed [14:0]  s1_gu_reg;
    logic signed [15:0]  s1_gv_reg;
    logic signed [17:0]  s1_bu_reg;
    logic                s1_sv_reg;
    logic                s1_last_reg;

    // Stage two: result register.
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [47:0]         out_data_reg;
    logic                out_sv_reg;
    logic                out_last_reg;

    logic                s1_en;
    logic                s2_en;
    logic [7:0]          c0;
    logic [7:0]          c1;
    logic signed [7:0]   d;
    logic signed [7:0]   e;
    logic signed [SUM_W-1:0] y0s;
    logic signed [SUM_W-1:0] y1s;
    logic signed [SUM_W-1:0] rv;
    logic signed [SUM_W-1:0] gc;
    logic signed [SUM_W-1:0] bu;
    logic [7:0]          r0;
    logic [7:0]          g0;
    logic [7:0]          b0;
    logic [7:0]          r1;
    logic [7:0]          g1;
    logic [7:0]          b1;

    // Stall chain: a stage loads when it is empty or its successor moves.
    assign s2_en = !out_valid_reg || m_axis_tready;
    assign s1_en = !s1_valid_reg || s2_en;
    assign q_pop = q_not_empty && s1_en;

    assign s1_valid_next  = s1_en ? q_not_empty : s1_valid_reg;
    assign out_valid_next = s2_en ? s1_valid_reg : out_valid_reg;

    // Luma offset with clamp at zero; chroma offset by flipping the top bit.
    assign c0 = (q_item.luma_first < 8'(LUMA_OFS)) ? 8'd0
                                                     : q_item.luma_first - 8'(LUMA_OFS);
    assign c1 = (q_item.luma_second < 8'(LUMA_OFS)) ? 8'd0
                                                      : q_item.luma_second - 8'(LUMA_OFS);
    assign d  = signed'({~q_item.chroma_blue[7], q_item.chroma_blue[6:0]});
    assign e  = signed'({~q_item.chroma_red[7], q_item.chroma_red[6:0]});

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_y0_reg   <= 17'(c0) * 17'(COEF_Y);
            s1_y1_reg   <= 17'(c1) * 17'(COEF_Y);
            s1_rv_reg   <= 17'(e) * 17'sd409;
            s1_gu_reg   <= 15'(d) * 15'sd100;
            s1_gv_reg   <= 16'(e) * 16'sd208;
            s1_bu_reg   <= 18'(d) * 18'sd516;
            s1_sv_reg   <= q_item.second_valid;
            s1_last_reg <= q_item.row_end;
        end
    end

    // Channel sums with rounding offset, then floor shift and clamp.
    assign y0s = SUM_W'(signed'({1'b0, s1_y0_reg})) + ROUND;
    assign y1s = SUM_W'(signed'({1'b0, s1_y1_reg})) + ROUND;
    assign rv  = SUM_W'(s1_rv_reg);
    assign gc  = -SUM_W'(s1_gu_reg) - SUM_W'(s1_gv_reg);
    assign bu  = SUM_W'(s1_bu_reg);

    assign r0 = shift_clamp(y0s + rv);
    assign g0 = shift_clamp(y0s + gc);
    assign b0 = shift_clamp(y0s + bu);
    assign r1 = shift_clamp(y1s + rv);
    assign g1 = shift_clamp(y1s + gc);
    assign b1 = shift_clamp(y1s + bu);

    always_ff @(posedge clk)
    begin
        if (s2_en)
        begin
            out_data_reg[23:0] <= {b0, g0, r0};
            if (s1_sv_reg)
                out_data_reg[47:24] <= {b1, g1, r1};
            else
                out_data_reg[47:24] <= '0;
            out_sv_reg   <= s1_sv_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_sv_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

[rtl/core/yuyv_to_rgb_converter_core.sv]
// Path: a macropixel accepted on s_axis goes through the queue, the product
// register and the result register before its beat appears on m_axis.
// One macropixel per cycle while the sink is ready; the two-entry queue and the
// result register let the input side keep taking beats while a result waits.
// Reset: rst_n clears the column counter and the queue, sets the row width
// to 640 (or MAX_WIDTH if smaller) and drops all valid flags at once.
// ----------------------------------------------------------------------------
// yuyv_to_rgb_converter_core
// Packed YUYV 4:2:2 to RGB888 conversion with BT.601 integer coefficients
// and row-end marking against a configurable row width.
// ----------------------------------------------------------------------------
module yuyv_to_rgb_converter_core #(
    parameter int MAX_WIDTH = yuyv2rgb_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Row width in pixels.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [yuyv2rgb_pkg::CFG_W-1:0] cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // luma_first, chroma_blue, luma_second, chroma_red (8 bits each)
    input  logic [31:0]                    s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // red_first, green_first, blue_first, red_second, green_second,
    // blue_second (8 bits each)
    output logic [47:0]                    m_axis_tdata,
    // second_valid
    output logic                           m_axis_tuser,
    // row_end
    output logic                           m_axis_tlast
);
    import yuyv2rgb_pkg::*;

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_not_empty;
    yuyv2rgb_item_t push_item;
    yuyv2rgb_item_t pop_item;

    // Front end: accept, count columns, tag beats.
    yuyv2rgb_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    // Decoupling queue.
    yuyv2rgb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (pop_item)
    );

    // Back end: conversion pipeline and result register.
    yuyv2rgb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_item        (pop_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

[rtl/core/yuyv2rgb_checker.sv]
// ----------------------------------------------------------------------------
// yuyv2rgb_checker
// Port-level checks on the result stream of the converter, bound to the top.
// ----------------------------------------------------------------------------
module yuyv2rgb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // A result beat waiting for the sink stays offered.
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat withdrawn while stalled");

    // A stalled result beat keeps its payload and flags.
    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // A second pixel outside the row can only occur on the pair ending it.
    a_invalid_second_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("second pixel invalid without row end");

    // A second pixel outside the row is reported as black.
    a_invalid_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[47:24] == 24'd0)
        else $error("invalid second pixel carries colour data");

endmodule

bind yuyv_to_rgb_converter_core yuyv2rgb_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

[test/yuyv_to_rgb_converter_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// yuyv_to_rgb_converter_core_tb
// Streams YUYV macropixels through the converter under random source gaps and
// sink stalls, predicts each RGB pair and its row flags in the testbench, and
// checks every result beat field by field. The row width is rewritten between
// phases, including zero, the maximum, values above it and mid-row changes.
// ----------------------------------------------------------------------------
module yuyv_to_rgb_converter_core_tb;
    import yuyv2rgb_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_PRINTED = 40;
    localparam int RANDOM_PHASES = 11;
    localparam int ITEMS_PER_PHASE = 105;

    // Expected result beat, packed in the same order as the output port.
    typedef struct packed {
        logic        row_end;
        logic        second_valid;
        logic [47:0] pixels;
    } rgb_pair_t;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [31:0]         s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [47:0]         m_axis_tdata;
    logic                m_axis_tuser;
    logic                m_axis_tlast;

    // Beats waiting to be sent, and results waiting to arrive.
    logic [31:0]         macropixel_queue [$];
    rgb_pair_t           pending_rgb [$];

    // Predictor copy of the block state and its register.
    int unsigned         model_width = FRAME_WIDTH_RESET;
    int unsigned         model_column = 0;

    bit                  gaps_on = 1'b1;
    int                  send_gap = 0;
    int                  stall_left = 0;
    int                  mismatch_count = 0;
    int                  result_count = 0;
    int                  cycle_count = 0;

    string channel_name [6] = '{"red_first", "green_first", "blue_first",
                                "red_second", "green_second", "blue_second"};

    yuyv_to_rgb_converter_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle length: mostly none, some short, a few long.
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (!gaps_on || pick < 70)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Byte that favours the clamp and offset boundaries now and then.
    function automatic logic [7:0] pick_byte(input bit is_luma);
        logic [7:0] luma_edges [6];
        logic [7:0] chroma_edges [6];
        luma_edges = '{8'd0, 8'd15, 8'd16, 8'd17, 8'd235, 8'd255};
        chroma_edges = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd255};
        if ($urandom_range(0, 3) != 0)
            return 8'($urandom_range(0, 255));
        return is_luma ? luma_edges[$urandom_range(0, 5)] : chroma_edges[$urandom_range(0, 5)];
    endfunction

    // Floor shift by eight of a channel sum, then clamp to one byte.
    function automatic logic [7:0] round_channel(input int sum);
        int scaled;
        scaled = sum >>> 8;
        if (scaled < 0)
            return 8'd0;
        if (scaled > 255)
            return 8'd255;
        return scaled[7:0];
    endfunction

    // BT.601 conversion of one pixel; blue in the top byte, red in the bottom.
    function automatic logic [23:0] bt601_pixel(input logic [7:0] luma,
                                                input logic [7:0] u_byte,
                                                input logic [7:0] v_byte);
        int c;
        int d;
        int e;
        c = int'(luma);
        c = c - LUMA_OFS;
        if (c < 0)
            c = 0;
        d = int'(u_byte);
        d = d - 128;
        e = int'(v_byte);
        e = e - 128;
        return {round_channel(COEF_Y * c + COEF_BU * d + ROUND_OFS),
                round_channel(COEF_Y * c - COEF_GU * d - COEF_GV * e + ROUND_OFS),
                round_channel(COEF_Y * c + COEF_RV * e + ROUND_OFS)};
    endfunction

    // Expected result of one macropixel; advances the column counter.
    function automatic rgb_pair_t predict_rgb_pair(input logic [31:0] macropixel);
        rgb_pair_t   pair;
        int unsigned row_width;
        row_width = model_width;
        if (row_width < 1)
            row_width = 1;
        if (row_width > MAX_WIDTH_DEFAULT)
            row_width = MAX_WIDTH_DEFAULT;
        pair.second_valid = (model_column + 1) < row_width;
        pair.row_end = (model_column + 2) >= row_width;
        pair.pixels[23:0] = bt601_pixel(macropixel[7:0], macropixel[15:8], macropixel[31:24]);
        if (pair.second_valid)
            pair.pixels[47:24] = bt601_pixel(macropixel[23:16], macropixel[15:8],
                                             macropixel[31:24]);
        else
            pair.pixels[47:24] = '0;
        model_column = pair.row_end ? 0 : model_column + 2;
        return pair;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
            $display("ERROR: %s", msg);
        mismatch_count++;
    endtask

    // Source side: one beat per handshake, with random gaps between beats.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                pending_rgb.push_back(predict_rgb_pair(s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (macropixel_queue.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= macropixel_queue.pop_front();
                    send_gap <= gap_length();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink side: check each accepted beat against the oldest expectation.
    always @(posedge clk)
    begin : sink
        rgb_pair_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_rgb.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              result_count));
                end
                else
                begin
                    want = pending_rgb.pop_front();
                    for (int k = 0; k < 6; k++)
                    begin
                        if (m_axis_tdata[8*k +: 8] !== want.pixels[8*k +: 8])
                            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                                      result_count, channel_name[k],
                                                      m_axis_tdata[8*k +: 8],
                                                      want.pixels[8*k +: 8]));
                    end
                    if (m_axis_tuser !== want.second_valid)
                        report_mismatch($sformatf("result %0d second_valid: got %b, expected %b",
                                                  result_count, m_axis_tuser,
                                                  want.second_valid));
                    if (m_axis_tlast !== want.row_end)
                        report_mismatch($sformatf("result %0d row_end: got %b, expected %b",
                                                  result_count, m_axis_tlast, want.row_end));
                end
                result_count++;
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left <= gap_length();
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("yuyv_to_rgb_converter_core_tb: FAIL");
            $finish;
        end
    end

    // Block until every queued beat has gone and every result has come back.
    // The check runs on the falling edge, once the driver's updates have settled.
    task automatic wait_idle();
        while (macropixel_queue.size() != 0 || s_axis_tvalid || pending_rgb.size() != 0)
            @(negedge clk);
    endtask

    // Write the row width once the block is idle.
    task automatic write_width(input int unsigned value);
        wait_idle();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value[CFG_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_width = value & ((1 << CFG_W) - 1);
    endtask

    task automatic queue_macropixel(input logic [7:0] y0, input logic [7:0] u_byte,
                                    input logic [7:0] y1, input logic [7:0] v_byte);
        macropixel_queue.push_back({v_byte, y1, u_byte, y0});
    endtask

    // Stimulus sequence.
    initial
    begin
        int unsigned widths [RANDOM_PHASES];
        widths = '{0, 1, 2, 4096, 4097, 8191, 640, 5, 0, 0, 6};
        widths[8] = $urandom_range(2, 40);
        widths[9] = $urandom_range(0, 8191);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed colours at the reset width: black, white, clamps, extremes.
        queue_macropixel(8'd0, 8'd0, 8'd0, 8'd0);
        queue_macropixel(8'd255, 8'd255, 8'd255, 8'd255);
        queue_macropixel(8'd16, 8'd128, 8'd16, 8'd128);
        queue_macropixel(8'd235, 8'd128, 8'd235, 8'd128);
        queue_macropixel(8'd15, 8'd128, 8'd17, 8'd128);
        queue_macropixel(8'd255, 8'd0, 8'd255, 8'd0);
        queue_macropixel(8'd255, 8'd255, 8'd0, 8'd0);
        queue_macropixel(8'd0, 8'd0, 8'd255, 8'd255);
        queue_macropixel(8'd128, 8'd0, 8'd128, 8'd255);
        queue_macropixel(8'd128, 8'd255, 8'd128, 8'd0);
        queue_macropixel(8'd81, 8'd90, 8'd81, 8'd240);
        queue_macropixel(8'd145, 8'd54, 8'd145, 8'd34);
        queue_macropixel(8'd41, 8'd240, 8'd41, 8'd110);
        queue_macropixel(8'd16, 8'd0, 8'd16, 8'd0);
        queue_macropixel(8'd255, 8'd128, 8'd0, 8'd128);
        queue_macropixel(8'd170, 8'd85, 8'd170, 8'd85);

        // Width cut below the current column, then an odd row end.
        write_width(3);
        queue_macropixel(8'd200, 8'd60, 8'd100, 8'd190);
        queue_macropixel(8'd90, 8'd200, 8'd30, 8'd20);
        queue_macropixel(8'd235, 8'd16, 8'd235, 8'd240);
        queue_macropixel(8'd50, 8'd128, 8'd60, 8'd128);

        // Random phases across the width settings, extremes included.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_width(widths[p]);
            gaps_on = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                queue_macropixel(pick_byte(1'b1), pick_byte(1'b0),
                                 pick_byte(1'b1), pick_byte(1'b0));
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("yuyv_to_rgb_converter_core_tb: PASS");
        else
            $display("yuyv_to_rgb_converter_core_tb: FAIL");
        $finish;
    end

endmodule
